// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked at every edge, also during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/rpn_pkg.sv -----
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, widths and codes of the RPN stack evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int VAL_W               = 48;
  localparam int FRAC_W              = 16;
  localparam int MUL_W               = 2 * VAL_W;
  localparam int DIV_W               = VAL_W + FRAC_W;
  localparam int DEFAULT_STACK_DEPTH = 16;
  localparam int CMD_W               = 2;
  localparam int CHAR_W              = 8;
  localparam int STATUS_W            = 3;

  typedef logic [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Token kinds.
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COUNT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNSUP = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_QUIT  = 3'd6;

  // Operator characters.
  localparam logic [CHAR_W-1:0] CH_ADD     = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SUB     = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_MUL     = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DIV     = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_QUIT_LO = 8'h71;
  localparam logic [CHAR_W-1:0] CH_QUIT_UP = 8'h51;

endpackage

// ----- hw/rtl/rpn_stack_evaluator.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Evaluates tokenized reverse Polish expressions on signed Q31.16 values.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis channel: tuser carries the token kind
// (push, operator, end), tdata the operand and the operator character. Only
// end tokens produce an item on m_axis: tuser is the status, tdata the top of
// stack when the status is ok, else zero.
// The top of stack lives in a register; the entries below it live in a
// synchronous single-port-read memory, so an operator needs one memory read.
// Push, end and rejected tokens take only the idle state; add and subtract
// also pass the read state; multiply makes four passes through a shared
// 24 x 24 multiplier; divide runs the 64-step restoring divider that produces
// one quotient bit a cycle. An end result is registered onto m_axis when it is free.
// Reset empties the stack and clears the latched error; there is no clearing
// pass, stack entries are only read after they have been pushed.
// While m_axis is stalled, further pushes and operators are still taken; a
// second end token is held inside and s_axis_tready stays low until the first
// result has been taken.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator import rpn_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [55:0]         s_axis_tdata,  // operand_value[47:0], operator_char[55:48]
  input  logic [CMD_W-1:0]    s_axis_tuser,  // command[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [VAL_W-1:0]    m_axis_tdata,  // value[47:0]
  output logic [STATUS_W-1:0] m_axis_tuser   // status[2:0]
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_HOLD = 3'd4;

  logic [2:0]          state;
  logic [CW-1:0]       count;
  logic [STATUS_W-1:0] lstat;
  val_t                top;
  logic [CHAR_W-1:0]   op_char;
  logic                res_neg;
  logic [STATUS_W-1:0] pend_status;
  val_t                pend_value;

  logic [CMD_W-1:0]    in_cmd;
  val_t                in_val;
  logic [CHAR_W-1:0]   in_ch;
  logic                accept, out_free, out_load;
  logic                is_quit, is_arith, is_div;
  logic [CW-1:0]       count_m1, count_m2;
  logic                mem_we, mem_re;
  val_t                rd_data;
  logic [VAL_W:0]      sum, diff;
  val_t                sum_sat, diff_sat;
  logic                mul_start, mul_done, div_start, div_done;
  logic [MUL_W-1:0]    prod;
  logic [DIV_W-1:0]    quot;
  val_t                mul_res, div_res;
  logic [STATUS_W-1:0] end_status;
  val_t                end_value;

  function automatic val_t mag48(input val_t v);
    mag48 = v[VAL_W-1] ? (~v + val_t'(1)) : v;
  endfunction

  // Applies a sign to a magnitude and clamps to the 48-bit range.
  function automatic val_t sat48(input logic neg, input logic over,
                                 input logic [VAL_W-2:0] m);
    if (over) begin
      sat48 = neg ? VAL_MIN : VAL_MAX;
    end else if (neg) begin
      sat48 = ~{1'b0, m} + val_t'(1);
    end else begin
      sat48 = {1'b0, m};
    end
  endfunction

  assign in_cmd = s_axis_tuser;
  assign in_val = s_axis_tdata[VAL_W-1:0];
  assign in_ch  = s_axis_tdata[VAL_W+CHAR_W-1:VAL_W];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // The result register takes a new end item or the one held inside.
  assign out_load = out_free && ((accept && (in_cmd == CMD_END)) || (state == S_HOLD));

  assign is_quit  = (in_ch == CH_QUIT_LO) || (in_ch == CH_QUIT_UP);
  assign is_div   = (in_ch == CH_DIV);
  assign is_arith = (in_ch == CH_ADD) || (in_ch == CH_SUB) || (in_ch == CH_MUL) || is_div;

  assign count_m1 = count - CW'(1);
  assign count_m2 = count - CW'(2);

  // A push spills the old top into the memory; an operator fetches the
  // entry just below the top.
  assign mem_we = accept && (in_cmd == CMD_PUSH) && (lstat == ST_OK)
                  && (count < CW'(STACK_DEPTH)) && (count != '0);
  assign mem_re = accept && (in_cmd == CMD_OP) && (lstat == ST_OK) && !is_quit
                  && is_arith && (count >= CW'(2)) && !(is_div && (top == '0));

  rpn_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_m1[AW-1:0]),
    .wdata (top),
    .re    (mem_re),
    .raddr (count_m2[AW-1:0]),
    .rdata (rd_data)
  );

  assign mul_start = (state == S_READ) && (op_char == CH_MUL);
  assign div_start = (state == S_READ) && (op_char == CH_DIV);

  rpn_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mag48(rd_data)),
    .b     (mag48(top)),
    .done  (mul_done),
    .prod  (prod)
  );

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mag48(rd_data), {FRAC_W{1'b0}}}),
    .divisor  (mag48(top)),
    .done     (div_done),
    .quot     (quot)
  );

  assign sum  = {rd_data[VAL_W-1], rd_data} + {top[VAL_W-1], top};
  assign diff = {rd_data[VAL_W-1], rd_data} - {top[VAL_W-1], top};

  always_comb begin
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      sum_sat = sum[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      sum_sat = sum[VAL_W-1:0];
    end
    if (diff[VAL_W] != diff[VAL_W-1]) begin
      diff_sat = diff[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      diff_sat = diff[VAL_W-1:0];
    end
  end

  // The product is scaled back by the fraction width; anything at or above
  // 2^47 after scaling saturates.
  assign mul_res = sat48(res_neg, |prod[MUL_W-1:VAL_W+FRAC_W-1],
                         prod[VAL_W+FRAC_W-2:FRAC_W]);
  assign div_res = sat48(res_neg, |quot[DIV_W-1:VAL_W-1], quot[VAL_W-2:0]);

  always_comb begin
    end_status = lstat;
    end_value  = '0;
    if (lstat == ST_OK) begin
      if (count == CW'(1)) begin
        end_value = top;
      end else begin
        end_status = ST_COUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      lstat         <= ST_OK;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_cmd)
              CMD_PUSH: begin
                if (lstat == ST_OK) begin
                  if (count >= CW'(STACK_DEPTH)) begin
                    lstat <= ST_FULL;
                  end else begin
                    top   <= in_val;
                    count <= count + CW'(1);
                  end
                end
              end
              CMD_OP: begin
                if (lstat == ST_OK) begin
                  if (is_quit) begin
                    lstat <= ST_QUIT;
                  end else if (!is_arith) begin
                    lstat <= ST_UNSUP;
                  end else if (count < CW'(2)) begin
                    lstat <= ST_UNDER;
                  end else if (is_div && (top == '0)) begin
                    lstat <= ST_DIVZ;
                  end else begin
                    op_char <= in_ch;
                    state   <= S_READ;
                  end
                end
              end
              CMD_END: begin
                count <= '0;
                lstat <= ST_OK;
                if (out_free) begin
                  m_axis_tuser  <= end_status;
                  m_axis_tdata  <= end_value;
                end else begin
                  pend_status <= end_status;
                  pend_value  <= end_value;
                  state       <= S_HOLD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          res_neg <= rd_data[VAL_W-1] ^ top[VAL_W-1];
          case (op_char)
            CH_ADD: begin
              top   <= sum_sat;
              count <= count_m1;
              state <= S_IDLE;
            end
            CH_SUB: begin
              top   <= diff_sat;
              count <= count_m1;
              state <= S_IDLE;
            end
            CH_MUL: state <= S_MUL;
            default: state <= S_DIV;
          endcase
        end
        S_MUL: begin
          if (mul_done) begin
            top   <= mul_res;
            count <= count_m1;
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            top   <= div_res;
            count <= count_m1;
            state <= S_IDLE;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            m_axis_tuser  <= pend_status;
            m_axis_tdata  <= pend_value;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rpn_stack_mem.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_mem
// Stack storage below the top entry: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rpn_stack_mem import rpn_pkg::*; #(
  parameter int DEPTH = DEFAULT_STACK_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  val_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output val_t          rdata
);

  val_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/rpn_mul.sv -----
// ----------------------------------------------------------------------------
// rpn_mul
// Unsigned 48 x 48 multiplier built from one 24 x 24 multiplier used in
// four passes, with a registered partial product and an accumulator.
// ----------------------------------------------------------------------------
module rpn_mul import rpn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  val_t             a,
  input  val_t             b,
  output logic             done,
  output logic [MUL_W-1:0] prod
);

  localparam int HALF_W = VAL_W / 2;

  logic [HALF_W-1:0] a_lo, a_hi, b_lo, b_hi;
  logic [2:0]        step;
  logic              running;
  logic [VAL_W-1:0]  pp;
  logic [1:0]        pp_sh;
  logic [HALF_W-1:0] op_a, op_b;
  logic [1:0]        sh_sel;
  logic [MUL_W-1:0]  pp_ext;

  // Partial products in order: lo*lo, lo*hi, hi*lo, hi*hi.
  always_comb begin
    case (step[1:0])
      2'd0:    begin op_a = a_lo; op_b = b_lo; sh_sel = 2'd0; end
      2'd1:    begin op_a = a_lo; op_b = b_hi; sh_sel = 2'd1; end
      2'd2:    begin op_a = a_hi; op_b = b_lo; sh_sel = 2'd1; end
      default: begin op_a = a_hi; op_b = b_hi; sh_sel = 2'd2; end
    endcase
  end

  always_comb begin
    case (pp_sh)
      2'd0:    pp_ext = {{VAL_W{1'b0}}, pp};
      2'd1:    pp_ext = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
      default: pp_ext = {pp, {VAL_W{1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 3'd1;
        if (step == 3'd4) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_lo <= a[HALF_W-1:0];
      a_hi <= a[VAL_W-1:HALF_W];
      b_lo <= b[HALF_W-1:0];
      b_hi <= b[VAL_W-1:HALF_W];
      prod <= '0;
    end else if (running) begin
      if (step != 3'd4) begin
        pp    <= op_a * op_b;
        pp_sh <= sh_sel;
      end
      if (step != 3'd0) begin
        prod <= prod + pp_ext;
      end
    end
  end

endmodule

// ----- hw/rtl/rpn_div.sv -----
// ----------------------------------------------------------------------------
// rpn_div
// Restoring unsigned divider: 64-bit dividend by 48-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_div import rpn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  val_t             divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [VAL_W-1:0] rem;
  val_t             dvs;
  logic [VAL_W:0]   shifted;
  logic [VAL_W+1:0] trial;

  assign shifted = {rem, quot[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DIV_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= divisor;
      quot <= dividend;
    end else if (running) begin
      // The remainder always stays below the divisor, so it fits in 48 bits.
      if (!trial[VAL_W+1]) begin
        rem  <= trial[VAL_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[VAL_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- hw/rtl/rpn_checker.sv -----
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks of the RPN stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpn_checker import rpn_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [VAL_W-1:0]    m_axis_tdata,
  input logic [STATUS_W-1:0] m_axis_tuser
);

  // A stalled result stays offered with the same value.
  `ASSERT_CLK_RST(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Only a successful evaluation reports a nonzero value.
  `ASSERT_CLK_RST(a_err_zero, clk, rst, m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0), "error result carries a value")

  // A new result follows an accepted item or a held end token.
  `ASSERT_CLK_RST(a_out_cause, clk, rst, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready) || $past(!s_axis_tready), "result without a cause")

  // After reset the block offers no result and is ready for items.
  `ASSERT_CLK(a_reset, clk, rst |=> !m_axis_tvalid && s_axis_tready, "bad state after reset")

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/tb_rpn_stack_evaluator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rpn_stack_evaluator
// Self-checking testbench for the RPN stack evaluator.
// ----------------------------------------------------------------------------
// A short table of directed tokens covers saturation at both ends, every
// operator, and each error status. It is followed by random expressions,
// mostly well formed and partly broken or pure noise. Each accepted token
// updates a local calculator model. Every end token queues an expected status
// and value, and each item taken from m_axis is compared with the oldest entry.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_rpn_stack_evaluator;
  import rpn_pkg::*;

  localparam int          DEPTH         = DEFAULT_STACK_DEPTH;
  localparam int          NUM_ROWS      = 32;
  localparam int unsigned TARGET_TOKENS = 1840;
  localparam int          DRAIN_CYCLES  = 100;
  localparam val_t        ONE           = 48'h1_0000;

  // The token kind that the block ignores.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    val_t                val;
  } calc_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    val_t                opnd;
    logic [CHAR_W-1:0]   ch;
    logic [4:0]          rep;
    logic                typed;
    logic [STATUS_W-1:0] st;
    val_t                val;
  } token_row_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [55:0]         s_tdata  = '0;   // operand_value[47:0], operator_char[55:48]
  logic [CMD_W-1:0]    s_tuser  = '0;   // command[1:0]
  logic                m_axis_tvalid;
  logic                m_tready = 1'b0;
  logic [VAL_W-1:0]    m_axis_tdata;    // value[47:0]
  logic [STATUS_W-1:0] m_axis_tuser;    // status[2:0]

  // Local copy of the calculator state.
  val_t                calc_stack [DEPTH];
  int unsigned         calc_depth  = 0;
  logic [STATUS_W-1:0] calc_status = ST_OK;

  calc_result_t pending_results [$];
  logic         burst           = 1'b0;
  int unsigned  tokens_sent     = 0;
  int unsigned  ends_sent       = 0;
  int unsigned  results_checked = 0;
  int unsigned  err_count       = 0;
  int unsigned  status_seen [8];

  rpn_stack_evaluator #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk = ~clk;

  function automatic logic [VAL_W-1:0] magnitude(input val_t v);
    return v[VAL_W-1] ? -v : v;
  endfunction

  // Any magnitude of 2^47 or more clamps to the end of the range.
  function automatic val_t sat_magnitude(input logic neg, input logic [MUL_W-1:0] m);
    if (m[MUL_W-1:VAL_W-1] != '0) begin
      return neg ? VAL_MIN : VAL_MAX;
    end
    return neg ? -m[VAL_W-1:0] : m[VAL_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] arith_char(input int unsigned k);
    case (k)
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  // Small values keep products and quotients mostly inside the range.
  function automatic val_t rand_operand();
    val_t             v;
    logic [VAL_W-1:0] m;
    case ($urandom_range(0, 9))
      0:       v = VAL_MAX;
      1:       v = VAL_MIN;
      2:       v = '0;
      3, 4:    v = val_t'({$urandom(), $urandom()});
      default: begin
        m = (VAL_W'($urandom_range(0, 255)) << FRAC_W) | VAL_W'($urandom_range(0, 65535));
        v = ($urandom_range(0, 1) == 1) ? -m : m;
      end
    endcase
    return v;
  endfunction

  task automatic evaluate_token(input logic [CMD_W-1:0] cmd, input val_t opnd,
                                input logic [CHAR_W-1:0] ch, output logic has_res,
                                output calc_result_t res);
    val_t             x;
    val_t             y;
    val_t             r;
    logic             neg;
    logic [VAL_W:0]   wide;
    logic [MUL_W-1:0] prod;
    logic [DIV_W-1:0] quot;
    has_res = 1'b0;
    res     = '0;
    case (cmd)
      CMD_PUSH: begin
        if (calc_status == ST_OK) begin
          if (calc_depth >= DEPTH) begin
            calc_status = ST_FULL;
          end else begin
            calc_stack[calc_depth] = opnd;
            calc_depth++;
          end
        end
      end
      CMD_OP: begin
        if (calc_status == ST_OK) begin
          if (ch == CH_QUIT_LO || ch == CH_QUIT_UP) begin
            calc_status = ST_QUIT;
          end else if (ch != CH_ADD && ch != CH_SUB && ch != CH_MUL && ch != CH_DIV) begin
            calc_status = ST_UNSUP;
          end else if (calc_depth < 2) begin
            calc_status = ST_UNDER;
          end else begin
            x   = calc_stack[calc_depth-2];
            y   = calc_stack[calc_depth-1];
            neg = x[VAL_W-1] ^ y[VAL_W-1];
            if (ch == CH_DIV && y == '0) begin
              calc_status = ST_DIVZ;
            end else begin
              if (ch == CH_ADD || ch == CH_SUB) begin
                wide = (ch == CH_ADD) ? {x[VAL_W-1], x} + {y[VAL_W-1], y}
                                      : {x[VAL_W-1], x} - {y[VAL_W-1], y};
                if (wide[VAL_W] != wide[VAL_W-1]) begin
                  r = wide[VAL_W] ? VAL_MIN : VAL_MAX;
                end else begin
                  r = wide[VAL_W-1:0];
                end
              end else if (ch == CH_MUL) begin
                prod = {{VAL_W{1'b0}}, magnitude(x)} * {{VAL_W{1'b0}}, magnitude(y)};
                r    = sat_magnitude(neg, prod >> FRAC_W);
              end else begin
                quot = {magnitude(x), {FRAC_W{1'b0}}} / {{FRAC_W{1'b0}}, magnitude(y)};
                r    = sat_magnitude(neg, {{(MUL_W-DIV_W){1'b0}}, quot});
              end
              calc_depth--;
              calc_stack[calc_depth-1] = r;
            end
          end
        end
      end
      CMD_END: begin
        has_res = 1'b1;
        res.st  = calc_status;
        res.val = '0;
        if (calc_status == ST_OK) begin
          if (calc_depth == 1) begin
            res.val = calc_stack[0];
          end else begin
            res.st = ST_COUNT;
          end
        end
        calc_depth  = 0;
        calc_status = ST_OK;
      end
      default: ;
    endcase
  endtask

  // Offers one token, waits for it to be taken, and queues what it yields.
  task automatic send_token(input logic [CMD_W-1:0] cmd, input val_t opnd,
                            input logic [CHAR_W-1:0] ch, input logic typed,
                            input calc_result_t typed_res);
    int unsigned  gap;
    logic         has_res;
    calc_result_t res;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ch, opnd};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    evaluate_token(cmd, opnd, ch, has_res, res);
    if (has_res) begin
      pending_results.push_back(typed ? typed_res : res);
      ends_sent++;
    end
    if (cmd != CMD_UNUSED) begin
      tokens_sent++;
    end
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: send_token(CMD_OP, rand_operand(), CHAR_W'($urandom_range(0, 255)), 1'b0, '0);
      1: send_token(CMD_OP, rand_operand(),
                    ($urandom_range(0, 1) == 1) ? CH_QUIT_LO : CH_QUIT_UP, 1'b0, '0);
      2: send_token(CMD_UNUSED, val_t'({$urandom(), $urandom()}),
                    CHAR_W'($urandom_range(0, 255)), 1'b0, '0);
      3: send_token(CMD_OP, rand_operand(), arith_char($urandom_range(0, 3)), 1'b0, '0);
      default: send_token(CMD_W'($urandom_range(0, 3)), val_t'({$urandom(), $urandom()}),
                          CHAR_W'($urandom_range(0, 255)), 1'b0, '0);
    endcase
  endtask

  task automatic send_expression();
    int unsigned kind;
    int unsigned target;
    int unsigned pushed;
    int unsigned depth;
    kind  = $urandom_range(0, 99);
    burst = ($urandom_range(0, 7) == 0);
    if (kind >= 95) begin
      repeat ($urandom_range(1, 8)) send_noise();
    end else if (kind >= 88) begin
      // Overfill the stack; the trailing operator is ignored after the error.
      repeat (DEPTH + $urandom_range(1, 3)) send_token(CMD_PUSH, rand_operand(), 8'h00, 1'b0, '0);
      send_token(CMD_OP, '0, arith_char($urandom_range(0, 3)), 1'b0, '0);
      send_token(CMD_END, '0, 8'h00, 1'b0, '0);
    end else begin
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(1, DEPTH) : $urandom_range(1, 5);
      pushed = 0;
      depth  = 0;
      while (pushed < target || depth > 1) begin
        if (kind >= 75 && $urandom_range(0, 7) == 0) begin
          send_noise();
        end
        if (depth < 2 || (pushed < target && $urandom_range(0, 1) == 1)) begin
          send_token(CMD_PUSH, rand_operand(), CHAR_W'($urandom_range(0, 255)), 1'b0, '0);
          pushed++;
          depth++;
        end else begin
          send_token(CMD_OP, val_t'({$urandom(), $urandom()}),
                     arith_char($urandom_range(0, 3)), 1'b0, '0);
          depth--;
        end
      end
      send_token(CMD_END, val_t'({$urandom(), $urandom()}),
                 CHAR_W'($urandom_range(0, 255)), 1'b0, '0);
    end
    if ($urandom_range(0, 29) == 0) begin
      wait_for_results();
    end
  endtask

  initial begin : stimulus
    token_row_t   rows [0:NUM_ROWS-1];
    calc_result_t typed_res;
    int           i;
    //          cmd         operand           char        rep    typed  status    value
    rows[0]  = '{CMD_END,    '0,               8'h00,      5'd1,  1'b1, ST_COUNT, '0};
    rows[1]  = '{CMD_PUSH,   VAL_MAX,          8'h00,      5'd1,  1'b0, ST_OK,    '0};
    rows[2]  = '{CMD_PUSH,   48'd1,            8'h00,      5'd1,  1'b0, ST_OK,    '0};
    rows[3]  = '{CMD_OP,     '0,               CH_ADD,     5'd1,  1'b0, ST_OK,    '0};
    rows[4]  = '{CMD_END,    '0,               8'h00,      5'd1,  1'b1, ST_OK,    VAL_MAX};
    rows[5]  = '{CMD_PUSH,   VAL_MIN,          8'h00,      5'd1,  1'b0, ST_OK,    '0};
    rows[6]  = '{CMD_PUSH,   48'd1,            8'h00,      5'd1,  1'b0, ST_OK,    '0};
    rows[7]  = '{CMD_OP,     '0,               CH_SUB,     5'd1,  1'b0, ST_OK,    '0};
    rows[8]  = '{CMD_END,    '0,               8'h00,      5'd1,  1'b1, ST_OK,    VAL_MIN};
    rows[9]  = '{CMD_PUSH,   VAL_MIN,          8'h00,      5'd2,  1'b0, ST_OK,    '0};
    rows[10] = '{CMD_OP,     '0,               CH_MUL,     5'd1,  1'b0, ST_OK,    '0};
    rows[11] = '{CMD_END,    '0,               8'h00,      5'd1,  1'b1, ST_OK,    VAL_MAX};
    rows[12] = '{CMD_PUSH,   48'h3_0000,       8'h00,      5'd1,  1'b0, ST_OK,    '0};
    rows[13] = '{CMD_PUSH,   '0,               8'h00,      5'd1,  1'b0, ST_OK,    '0};
    rows[14] = '{CMD_OP,     '0,               CH_DIV,     5'd1,  1'b0, ST_OK,    '0};
    rows[15] = '{CMD_END,    '0,               8'h00,      5'd1,  1'b1, ST_DIVZ,  '0};
    rows[16] = '{CMD_OP,     '0,               CH_ADD,     5'd1,  1'b0, ST_OK,    '0};
    rows[17] = '{CMD_OP,     '0,               CH_QUIT_UP, 5'd1,  1'b0, ST_OK,    '0};
    rows[18] = '{CMD_END,    '0,               8'h00,      5'd1,  1'b1, ST_UNDER, '0};
    rows[19] = '{CMD_OP,     '0,               CH_QUIT_LO, 5'd1,  1'b0, ST_OK,    '0};
    rows[20] = '{CMD_END,    '0,               8'h00,      5'd1,  1'b1, ST_QUIT,  '0};
    rows[21] = '{CMD_OP,     {VAL_W{1'b1}},    8'hFF,      5'd1,  1'b0, ST_OK,    '0};
    rows[22] = '{CMD_END,    '0,               8'h00,      5'd1,  1'b1, ST_UNSUP, '0};
    rows[23] = '{CMD_UNUSED, {VAL_W{1'b1}},    8'hFF,      5'd1,  1'b0, ST_OK,    '0};
    rows[24] = '{CMD_PUSH,   ONE,              8'h00,      5'd17, 1'b0, ST_OK,    '0};
    rows[25] = '{CMD_END,    '0,               8'h00,      5'd1,  1'b1, ST_FULL,  '0};
    rows[26] = '{CMD_PUSH,   -48'sd491520,     8'h00,      5'd1,  1'b0, ST_OK,    '0};
    rows[27] = '{CMD_PUSH,   48'h2_0000,       8'h00,      5'd1,  1'b0, ST_OK,    '0};
    rows[28] = '{CMD_OP,     '0,               CH_DIV,     5'd1,  1'b0, ST_OK,    '0};
    rows[29] = '{CMD_PUSH,   48'h8000,         8'h00,      5'd1,  1'b0, ST_OK,    '0};
    rows[30] = '{CMD_OP,     '0,               CH_MUL,     5'd1,  1'b0, ST_OK,    '0};
    rows[31] = '{CMD_END,    '0,               8'h00,      5'd1,  1'b0, ST_OK,    '0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < NUM_ROWS; i++) begin
      typed_res = '{rows[i].st, rows[i].val};
      repeat (rows[i].rep) begin
        send_token(rows[i].cmd, rows[i].opnd, rows[i].ch, rows[i].typed, typed_res);
      end
    end
    wait_for_results();

    while (tokens_sent < TARGET_TOKENS) begin
      send_expression();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, pending_results.size());
      err_count++;
    end

    $display("Sent %0d tokens in %0d expressions; checked %0d results, %0d mismatches.",
             tokens_sent, ends_sent, results_checked, err_count);
    $display("Statuses seen: ok %0d, count %0d, full %0d, under %0d, unsup %0d, divz %0d, quit %0d",
             status_seen[ST_OK], status_seen[ST_COUNT], status_seen[ST_FULL],
             status_seen[ST_UNDER], status_seen[ST_UNSUP], status_seen[ST_DIVZ],
             status_seen[ST_QUIT]);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : result_check
    int unsigned  stall;
    int unsigned  calm_left;
    calc_result_t want;
    calm_left = 0;
    @(negedge rst);
    forever begin
      // Now and then a run of results is taken with no stall at all.
      if (calm_left == 0 && $urandom_range(0, 9) == 0) begin
        calm_left = $urandom_range(5, 20);
      end
      if (calm_left != 0) begin
        stall = 0;
        calm_left--;
      end else begin
        stall = $urandom_range(0, 8);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      results_checked++;
      status_seen[m_axis_tuser]++;
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual status %0d value %h",
                 $time, m_axis_tuser, m_axis_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.st) begin
          $display("%0t ns: status mismatch, expected %0d, actual %0d",
                   $time, want.st, m_axis_tuser);
          err_count++;
        end
        if (m_axis_tdata !== want.val) begin
          $display("%0t ns: value mismatch, expected %h, actual %h",
                   $time, want.val, m_axis_tdata);
          err_count++;
        end
      end
    end
  end

  // Several times the slowest legal run: every token dividing, every gap and
  // stall at its longest.
  initial begin : watchdog
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_stack_mem.sv
hw/rtl/rpn_mul.sv
hw/rtl/rpn_div.sv
hw/rtl/rpn_stack_evaluator.sv
hw/rtl/rpn_checker.sv
dv/tb_rpn_stack_evaluator.sv
